/* rtl/core/soft_sphere_pair_force_top_macros.svh */
// Assertion shorthands shared by the pair force block.
`ifndef SOFT_SPHERE_PAIR_FORCE_TOP_MACROS_SVH
`define SOFT_SPHERE_PAIR_FORCE_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SSPF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sspf implication check failed");

// Condition must never be seen.
`define SSPF_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("sspf forbidden condition seen");

`endif

/* rtl/core/sspf_pkg.sv */
package sspf_pkg;

   localparam int FRAC_BITS = 16;
   localparam int POS_W     = 24;
   localparam int RAD_W     = 18;
   localparam int SUMR_W    = RAD_W + 1;
   localparam int DELTA_W   = POS_W + 1;
   localparam int SQ_W      = 2 * DELTA_W;
   localparam int D2_W      = 2 * SUMR_W;
   localparam int ROOT_W    = SUMR_W;
   localparam int NUM_W     = SUMR_W + FRAC_BITS;
   localparam int FORCE_W   = 20;
   localparam int AMT_W     = POS_W;
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;

   localparam logic [AMT_W-1:0] AMT_MAX = {AMT_W{1'b1}};

   // Register indexes on paddr[2]
   localparam logic REG_BOX_LENGTH = 1'b0;
   localparam logic REG_NBR_RAD_SQ = 1'b1;

   localparam logic [POS_W-1:0] BOX_LENGTH_RST = 24'd4194304;
   localparam logic [POS_W-1:0] NBR_RAD_SQ_RST = 24'd409600;

   // Flags and magnitudes that ride alongside the distance math
   typedef struct packed {
      logic              nb;
      logic              ovl;
      logic              zero;
      logic              pos_x;
      logic              pos_y;
      logic [SUMR_W-1:0] mag_x;
      logic [SUMR_W-1:0] mag_y;
      logic [SUMR_W-1:0] sum_r;
   } sspf_side_type;

endpackage

/* rtl/core/sspf_geom.sv */
module sspf_geom (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic signed [sspf_pkg::POS_W-1:0] x_first,
   input  logic signed [sspf_pkg::POS_W-1:0] y_first,
   input  logic signed [sspf_pkg::POS_W-1:0] x_second,
   input  logic signed [sspf_pkg::POS_W-1:0] y_second,
   input  logic [sspf_pkg::RAD_W-1:0]    radius_first,
   input  logic [sspf_pkg::RAD_W-1:0]    radius_second,
   input  logic [sspf_pkg::POS_W-1:0]    box_length,
   input  logic [sspf_pkg::POS_W-1:0]    neighbor_radius_sq,
   output logic                          out_valid,
   output logic [sspf_pkg::D2_W-1:0]     out_d2,
   output sspf_pkg::sspf_side_type       out_side
);
   import sspf_pkg::*;

   logic [3:0] valid_ff;

   logic signed [DELTA_W-1:0] dlx_ff, dly_ff;
   logic [SUMR_W-1:0]         sr1_ff, sr2_ff, sr3_ff;
   logic signed [DELTA_W-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [SQ_W-1:0]           sqx_ff, sqy_ff;
   logic [D2_W-1:0]           srsq_ff;
   logic                      posx_ff, posy_ff;
   logic [SUMR_W-1:0]         magx_ff, magy_ff;
   logic [DELTA_W-1:0]        ax, ay;
   logic [SQ_W:0]             d2_full;
   logic [D2_W-1:0]           d2_ff;
   sspf_side_type             side_ff, side_in;

   // Wrap one component by the box, one correction at most
   function automatic logic signed [DELTA_W-1:0] wrap(
      input logic signed [DELTA_W-1:0] d, input logic [POS_W-1:0] len);
      logic signed [DELTA_W+1:0] two, l2, res;
      two = {d[DELTA_W-1], d, 1'b0};
      l2  = signed'({3'b000, len});
      res = {{2{d[DELTA_W-1]}}, d};
      if (two < -l2)
         res = res + l2;
      else if (two >= l2)
         res = res - l2;
      return res[DELTA_W-1:0];
   endfunction

   assign dx_in = wrap(dlx_ff, box_length);
   assign dy_in = wrap(dly_ff, box_length);
   assign ax    = dx_ff[DELTA_W-1] ? DELTA_W'(-dx_ff) : DELTA_W'(dx_ff);
   assign ay    = dy_ff[DELTA_W-1] ? DELTA_W'(-dy_ff) : DELTA_W'(dy_ff);
   assign d2_full = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   // Classify the pair on the summed squares
   always_comb begin
      side_in       = '0;
      side_in.nb    = d2_full < {{(SQ_W+1-POS_W-FRAC_BITS){1'b0}}, neighbor_radius_sq,
                                 {FRAC_BITS{1'b0}}};
      side_in.ovl   = side_in.nb && (d2_full < {{(SQ_W+1-D2_W){1'b0}}, srsq_ff});
      side_in.zero  = d2_full == '0;
      side_in.pos_x = posx_ff;
      side_in.pos_y = posy_ff;
      side_in.mag_x = magx_ff;
      side_in.mag_y = magy_ff;
      side_in.sum_r = sr3_ff;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= '0;
      else if (advance)
         valid_ff <= {valid_ff[2:0], in_valid};
   end

   // Advance the payload stages
   always_ff @(posedge clock) begin
      if (advance) begin
         dlx_ff  <= DELTA_W'(x_second) - DELTA_W'(x_first);
         dly_ff  <= DELTA_W'(y_second) - DELTA_W'(y_first);
         sr1_ff  <= SUMR_W'(radius_first) + SUMR_W'(radius_second);
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         sr2_ff  <= sr1_ff;
         sqx_ff  <= ax * ax;
         sqy_ff  <= ay * ay;
         srsq_ff <= sr2_ff * sr2_ff;
         posx_ff <= !dx_ff[DELTA_W-1] && (dx_ff != '0);
         posy_ff <= !dy_ff[DELTA_W-1] && (dy_ff != '0);
         magx_ff <= ax[SUMR_W-1:0];
         magy_ff <= ay[SUMR_W-1:0];
         sr3_ff  <= sr2_ff;
         d2_ff   <= d2_full[D2_W-1:0];
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_d2    = d2_ff;
   assign out_side  = side_ff;

endmodule

/* rtl/core/sspf_sqrt.sv */
module sspf_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic [sspf_pkg::D2_W-1:0]   in_d2,
   input  sspf_pkg::sspf_side_type     in_side,
   output logic                        out_valid,
   output logic [sspf_pkg::ROOT_W-1:0] out_root,
   output sspf_pkg::sspf_side_type     out_side
);
   import sspf_pkg::*;

   localparam int STEPS = ROOT_W;
   localparam int REM_W = ROOT_W + 3;

   logic [STEPS-1:0]  valid_ff;
   logic [D2_W-1:0]   rad_ff  [STEPS];
   logic [REM_W-1:0]  rem_ff  [STEPS];
   logic [ROOT_W-1:0] root_ff [STEPS];
   sspf_side_type     side_ff [STEPS];

   // One root bit per stage
   for (genvar s = 0; s < STEPS; s++) begin : g_step
      logic [D2_W-1:0]   rad_prev;
      logic [REM_W-1:0]  rem_prev, cur, trial;
      logic [ROOT_W-1:0] root_prev;
      logic              v_prev, take;
      sspf_side_type     side_prev;

      if (s == 0) begin : g_head
         assign rad_prev  = in_d2;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign v_prev    = in_valid;
         assign side_prev = in_side;
      end else begin : g_body
         assign rad_prev  = rad_ff[s-1];
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
         assign v_prev    = valid_ff[s-1];
         assign side_prev = side_ff[s-1];
      end

      assign cur   = {rem_prev[REM_W-3:0], rad_prev[D2_W-1 -: 2]};
      assign trial = {1'b0, root_prev, 2'b01};
      assign take  = cur >= trial;

      always_ff @(posedge clock) begin
         if (reset)
            valid_ff[s] <= 1'b0;
         else if (advance)
            valid_ff[s] <= v_prev;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rad_ff[s]  <= {rad_prev[D2_W-3:0], 2'b00};
            rem_ff[s]  <= take ? cur - trial : cur;
            root_ff[s] <= {root_prev[ROOT_W-2:0], take};
            side_ff[s] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_root  = root_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

/* rtl/core/sspf_div.sv */
module sspf_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic [sspf_pkg::ROOT_W-1:0] in_root,
   input  sspf_pkg::sspf_side_type     in_side,
   output logic                        out_valid,
   output logic [sspf_pkg::NUM_W-1:0]  out_quo,
   output sspf_pkg::sspf_side_type     out_side
);
   import sspf_pkg::*;

   localparam int STEPS = NUM_W;

   logic [STEPS-1:0]  valid_ff;
   logic [NUM_W-1:0]  num_ff  [STEPS];
   logic [ROOT_W-1:0] rem_ff  [STEPS];
   logic [NUM_W-1:0]  quo_ff  [STEPS];
   logic [ROOT_W-1:0] dvs_ff  [STEPS];
   sspf_side_type     side_ff [STEPS];

   // One quotient bit per stage, restoring
   for (genvar s = 0; s < STEPS; s++) begin : g_step
      logic [NUM_W-1:0]  num_prev, quo_prev;
      logic [ROOT_W-1:0] rem_prev, dvs_prev;
      logic [ROOT_W:0]   cur, diff;
      logic              v_prev, take;
      sspf_side_type     side_prev;

      if (s == 0) begin : g_head
         assign num_prev  = {in_side.sum_r, {FRAC_BITS{1'b0}}};
         assign quo_prev  = '0;
         assign rem_prev  = '0;
         assign dvs_prev  = in_root;
         assign v_prev    = in_valid;
         assign side_prev = in_side;
      end else begin : g_body
         assign num_prev  = num_ff[s-1];
         assign quo_prev  = quo_ff[s-1];
         assign rem_prev  = rem_ff[s-1];
         assign dvs_prev  = dvs_ff[s-1];
         assign v_prev    = valid_ff[s-1];
         assign side_prev = side_ff[s-1];
      end

      assign cur  = {rem_prev, num_prev[NUM_W-1]};
      assign diff = cur - {1'b0, dvs_prev};
      assign take = cur >= {1'b0, dvs_prev};

      always_ff @(posedge clock) begin
         if (reset)
            valid_ff[s] <= 1'b0;
         else if (advance)
            valid_ff[s] <= v_prev;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            num_ff[s]  <= {num_prev[NUM_W-2:0], 1'b0};
            rem_ff[s]  <= take ? diff[ROOT_W-1:0] : cur[ROOT_W-1:0];
            quo_ff[s]  <= {quo_prev[NUM_W-2:0], take};
            dvs_ff[s]  <= dvs_prev;
            side_ff[s] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_quo   = quo_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

/* rtl/core/sspf_force.sv */
module sspf_force (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             in_valid,
   input  logic [sspf_pkg::NUM_W-1:0]       in_quo,
   input  sspf_pkg::sspf_side_type          in_side,
   output logic                             out_valid,
   output logic                             out_is_neighbor,
   output logic                             out_overlaps,
   output logic signed [sspf_pkg::FORCE_W-1:0] out_force_x,
   output logic signed [sspf_pkg::FORCE_W-1:0] out_force_y,
   output logic [sspf_pkg::AMT_W-1:0]       out_overlap_amount
);
   import sspf_pkg::*;

   localparam int LO_W  = 18;
   localparam int HI_W  = NUM_W - LO_W;
   localparam int SUM_W = NUM_W + SUMR_W + 1;
   localparam int PRD_W = SUM_W - FRAC_BITS;
   localparam logic [NUM_W-1:0] ONE = NUM_W'(1) << FRAC_BITS;
   localparam logic [PRD_W-1:0] FMAX = PRD_W'((1 << (FORCE_W-1)) - 1);
   localparam logic [PRD_W-1:0] FMIN_MAG = PRD_W'(1 << (FORCE_W-1));

   logic [2:0]           valid_ff;
   logic [NUM_W-1:0]     ov_ff;
   logic [AMT_W-1:0]     amt1_ff, amt2_ff, amt_ff;
   sspf_side_type        side1_ff, side2_ff;
   logic [LO_W+SUMR_W-1:0] plx_ff, ply_ff;
   logic [HI_W+SUMR_W-1:0] phx_ff, phy_ff;
   logic                 nb_ff, ovl_ff;
   logic signed [FORCE_W-1:0] fx_ff, fy_ff;
   logic [AMT_W-1:0]     amt_in;
   logic [NUM_W-1:0]     ov_in;
   logic                 live;

   assign ov_in = (in_quo >= ONE) ? in_quo - ONE : '0;

   // Saturated overlap amount
   always_comb begin
      if (!in_side.ovl)
         amt_in = '0;
      else if (in_side.zero || ov_in > NUM_W'(AMT_MAX))
         amt_in = AMT_MAX;
      else
         amt_in = ov_in[AMT_W-1:0];
   end

   // Recombine partial products, shift, saturate and oppose dr
   function automatic logic signed [FORCE_W-1:0] finish(
      input logic [LO_W+SUMR_W-1:0] plo, input logic [HI_W+SUMR_W-1:0] phi,
      input logic pos, input logic en);
      logic [SUM_W-1:0] sum;
      logic [PRD_W-1:0] prd;
      logic [FORCE_W-1:0] res;
      sum = SUM_W'(plo) + (SUM_W'(phi) << LO_W);
      prd = sum[SUM_W-1:FRAC_BITS];
      if (!en)
         res = '0;
      else if (pos)
         res = (prd > FMIN_MAG) ? FMIN_MAG[FORCE_W-1:0] : FORCE_W'(-prd);
      else
         res = (prd > FMAX) ? FMAX[FORCE_W-1:0] : prd[FORCE_W-1:0];
      return res;
   endfunction

   assign live = side2_ff.ovl && !side2_ff.zero;

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= '0;
      else if (advance)
         valid_ff <= {valid_ff[1:0], in_valid};
   end

   // Advance: overlap, partial products, result register
   always_ff @(posedge clock) begin
      if (advance) begin
         ov_ff    <= ov_in;
         amt1_ff  <= amt_in;
         side1_ff <= in_side;
         plx_ff   <= ov_ff[LO_W-1:0] * side1_ff.mag_x;
         ply_ff   <= ov_ff[LO_W-1:0] * side1_ff.mag_y;
         phx_ff   <= ov_ff[NUM_W-1:LO_W] * side1_ff.mag_x;
         phy_ff   <= ov_ff[NUM_W-1:LO_W] * side1_ff.mag_y;
         amt2_ff  <= amt1_ff;
         side2_ff <= side1_ff;
         nb_ff    <= side2_ff.nb;
         ovl_ff   <= side2_ff.ovl;
         amt_ff   <= amt2_ff;
         fx_ff    <= finish(plx_ff, phx_ff, side2_ff.pos_x, live);
         fy_ff    <= finish(ply_ff, phy_ff, side2_ff.pos_y, live);
      end
   end

   assign out_valid          = valid_ff[2];
   assign out_is_neighbor    = nb_ff;
   assign out_overlaps       = ovl_ff;
   assign out_force_x        = fx_ff;
   assign out_force_y        = fy_ff;
   assign out_overlap_amount = amt_ff;

endmodule

/* rtl/core/soft_sphere_pair_force_top.sv */
// Harmonic soft-sphere pair force with minimum-image wrap in 2-D.
// Input channel req_*: one particle pair per beat (two positions, two radii).
// Result channel rsp_*: neighbor flag, overlap flag, force on particle i and
// the overlap amount; exactly one result beat per input beat, in order.
// Stages from accepted input beat to rsp_valid, in order:
// 4 geometry stages, 19 square-root stages (one root bit each), 35 divider
// stages (one quotient bit each) and 3 force stages ending in the output
// register. Throughput: one pair per cycle when not stalled; the divider depth sets latency.
// The whole pipe moves on one enable: while rsp_valid is high and rsp_stall
// is high, every stage holds and req_stall goes high; otherwise a new beat is
// taken each cycle even while the output register is full and being drained.
// Reset (synchronous) clears all valid bits and loads box_length = 64.0 and
// neighbor_radius_sq = 6.25. Registers sit on the APB port: box_length at
// byte address 0, neighbor_radius_sq at 4; write only while the pipe is empty.
module soft_sphere_pair_force_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [sspf_pkg::POS_W-1:0]    req_x_first,
   input  logic signed [sspf_pkg::POS_W-1:0]    req_y_first,
   input  logic signed [sspf_pkg::POS_W-1:0]    req_x_second,
   input  logic signed [sspf_pkg::POS_W-1:0]    req_y_second,
   input  logic [sspf_pkg::RAD_W-1:0]           req_radius_first,
   input  logic [sspf_pkg::RAD_W-1:0]           req_radius_second,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_is_neighbor,
   output logic                                 rsp_overlaps,
   output logic signed [sspf_pkg::FORCE_W-1:0]  rsp_force_x,
   output logic signed [sspf_pkg::FORCE_W-1:0]  rsp_force_y,
   output logic [sspf_pkg::AMT_W-1:0]           rsp_overlap_amount,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [sspf_pkg::ADDR_W-1:0]          paddr,
   input  logic [sspf_pkg::DATA_W-1:0]          pwdata,
   output logic [sspf_pkg::DATA_W-1:0]          prdata,
   output logic                                 pready
);
   import sspf_pkg::*;

   logic              advance;
   logic [POS_W-1:0]  box_ff, nbr_ff;
   logic              csr_wr;

   logic              g_valid, s_valid, d_valid;
   logic [D2_W-1:0]   g_d2;
   logic [ROOT_W-1:0] s_root;
   logic [NUM_W-1:0]  d_quo;
   sspf_side_type     g_side, s_side, d_side;

   // Hold every stage while the output beat is stalled
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // Register file
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff <= BOX_LENGTH_RST;
         nbr_ff <= NBR_RAD_SQ_RST;
      end else if (csr_wr) begin
         unique case (paddr[2])
            REG_BOX_LENGTH: box_ff <= pwdata[POS_W-1:0];
            REG_NBR_RAD_SQ: nbr_ff <= pwdata[POS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_BOX_LENGTH: prdata = DATA_W'(box_ff);
         REG_NBR_RAD_SQ: prdata = DATA_W'(nbr_ff);
         default:        prdata = '0;
      endcase
   end

   sspf_geom u_geom (
      .clock              (clock),
      .reset              (reset),
      .advance            (advance),
      .in_valid           (req_valid),
      .x_first            (req_x_first),
      .y_first            (req_y_first),
      .x_second           (req_x_second),
      .y_second           (req_y_second),
      .radius_first       (req_radius_first),
      .radius_second      (req_radius_second),
      .box_length         (box_ff),
      .neighbor_radius_sq (nbr_ff),
      .out_valid          (g_valid),
      .out_d2             (g_d2),
      .out_side           (g_side)
   );

   sspf_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (g_valid),
      .in_d2     (g_d2),
      .in_side   (g_side),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_side  (s_side)
   );

   sspf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s_valid),
      .in_root   (s_root),
      .in_side   (s_side),
      .out_valid (d_valid),
      .out_quo   (d_quo),
      .out_side  (d_side)
   );

   sspf_force u_force (
      .clock              (clock),
      .reset              (reset),
      .advance            (advance),
      .in_valid           (d_valid),
      .in_quo             (d_quo),
      .in_side            (d_side),
      .out_valid          (rsp_valid),
      .out_is_neighbor    (rsp_is_neighbor),
      .out_overlaps       (rsp_overlaps),
      .out_force_x        (rsp_force_x),
      .out_force_y        (rsp_force_y),
      .out_overlap_amount (rsp_overlap_amount)
   );

`include "soft_sphere_pair_force_top_macros.svh"

   `SSPF_ASSERT_NEVER(a_ovl_needs_nb, clock, reset, rsp_valid && rsp_overlaps && !rsp_is_neighbor)
   `SSPF_ASSERT_IMP(a_no_ovl_zero, clock, reset, rsp_valid && !rsp_overlaps, rsp_force_x == '0 && rsp_force_y == '0 && rsp_overlap_amount == '0)
   `SSPF_ASSERT_IMP(a_zero_amt_zero_f, clock, reset, rsp_valid && rsp_overlap_amount == '0, rsp_force_x == '0 && rsp_force_y == '0)

endmodule
